// ===== hw/rtl/sfcd_pkg.sv =====
// Shared types, constants and helpers of the stuffed frame channel decoder.
// No dependencies; used by the parser, the core and the checker.
`default_nettype none

package sfcd_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int PACKET_BYTES = 14;
   localparam int LINE_BYTES   = 32;
   localparam int MAX_RESULTS  = 8;
   localparam int CHAN_COUNT   = (NUM_CHANNELS < MAX_RESULTS) ? NUM_CHANNELS : MAX_RESULTS;

   localparam int COUNT_W = 6;
   localparam int ADDR_W  = $clog2(PACKET_BYTES);
   localparam int CSR_W   = 3;

   localparam logic [12:0] CHANNEL_OFFSET = 13'd1500;

   localparam logic [CSR_W-1:0] CSR_DELIMITER  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_ESCAPE     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_MASK       = 3'd2;
   localparam logic [CSR_W-1:0] CSR_FRAME_TYPE = 3'd3;

   localparam logic [7:0] RST_DELIMITER  = 8'd126;
   localparam logic [7:0] RST_ESCAPE     = 8'd125;
   localparam logic [7:0] RST_MASK       = 8'd32;
   localparam logic [7:0] RST_FRAME_TYPE = 8'd128;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_START = 4'b0010,
      MODE_FRAME = 4'b0100,
      MODE_ESC   = 4'b1000
   } mode_type;

   typedef enum logic [2:0] {
      SEQ_ACCEPT = 3'b001,
      SEQ_LOAD   = 3'b010,
      SEQ_EMIT   = 3'b100
   } seq_type;

   typedef struct packed {
      logic [7:0] delimiter;
      logic [7:0] escape;
      logic [7:0] mask;
      logic [7:0] frame_type;
   } cfg_type;

   typedef struct packed {
      mode_type   next_mode;
      logic       clear;
      logic       append;
      logic [7:0] data;
   } parse_type;

   function automatic logic [11:0] chan_raw(input logic odd, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2);
      logic [11:0] raw;
      if (odd) begin
         raw = {b2[3:0], b1[3:0], b2[7:4]};
      end else begin
         raw = {b1[7:4], b0};
      end
      return raw;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfcd_parser.sv =====
// Delimiter and escape parser: decides the next mode and what to append for one byte.
// Depends on sfcd_pkg.
`default_nettype none

module sfcd_parser (
   input  wire sfcd_pkg::mode_type  mode,
   input  wire logic [7:0]          rx_byte,
   input  wire sfcd_pkg::cfg_type   cfg,
   output sfcd_pkg::parse_type      result
);

   logic is_delim;
   logic is_esc;
   logic is_stuffed;

   assign is_delim   = (rx_byte == cfg.delimiter);
   assign is_esc     = (rx_byte == cfg.escape);
   assign is_stuffed = (rx_byte == (cfg.escape ^ cfg.mask)) ||
                       (rx_byte == (cfg.delimiter ^ cfg.mask));

   always_comb begin
      result.next_mode = mode;
      result.clear     = 1'b0;
      result.append    = 1'b0;
      result.data      = rx_byte;
      case (mode)
         sfcd_pkg::MODE_IDLE: begin
            if (is_delim) begin
               result.clear     = 1'b1;
               result.next_mode = sfcd_pkg::MODE_START;
            end else begin
               result.append = 1'b1;
            end
         end
         sfcd_pkg::MODE_START: begin
            if (is_delim) begin
               result.clear     = 1'b1;
               result.next_mode = sfcd_pkg::MODE_FRAME;
            end else begin
               result.append = 1'b1;
            end
         end
         sfcd_pkg::MODE_FRAME: begin
            if (is_esc) begin
               result.next_mode = sfcd_pkg::MODE_ESC;
            end else if (is_delim) begin
               result.clear = 1'b1;
            end else begin
               result.append = 1'b1;
            end
         end
         default: begin
            if (is_stuffed) begin
               result.append    = 1'b1;
               result.data      = rx_byte ^ cfg.mask;
               result.next_mode = sfcd_pkg::MODE_FRAME;
            end else if (is_delim) begin
               result.clear     = 1'b1;
               result.next_mode = sfcd_pkg::MODE_FRAME;
            end else begin
               result.next_mode = sfcd_pkg::MODE_START;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stuffed_frame_channel_decoder_core.sv =====
// Top level of the stuffed frame channel decoder: frame store memory, checksum and
// channel output sequencer. Depends on sfcd_pkg and sfcd_parser.
// An input item is taken only while no frame is being loaded or emitted.
// After the byte that completes a good frame, the sequencer loads the first channel pair
// from the frame store and then registers the first result. Each pair is read from the
// store byte by byte before its two results go out; the store has a single read port.
// Synchronous reset clears the parse mode, write count, sequencer and output valid and
// restores the register defaults; the frame store is not cleared.
`default_nettype none

module stuffed_frame_channel_decoder_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,   // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [2:0] channel_index, [15:3] channel_value
   output logic                              rsp_tlast,   // last_channel
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [sfcd_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [7:0]                   csr_data
);

   localparam int CW = sfcd_pkg::COUNT_W;
   localparam int AW = sfcd_pkg::ADDR_W;

   sfcd_pkg::cfg_type   cfg_ff, cfg_in;
   sfcd_pkg::mode_type  mode_ff, mode_in;
   sfcd_pkg::seq_type   seq_ff, seq_in;
   sfcd_pkg::parse_type parse;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    acc_ff, acc_in;
   logic [7:0]    type_ff, type_in;
   logic [1:0]    pair_ff, pair_in;
   logic          half_ff, half_in;
   logic [1:0]    step_ff, step_in;
   logic [7:0]    b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_index_ff, rsp_index_in;
   logic [12:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]    store_mem [sfcd_pkg::PACKET_BYTES];
   logic [7:0]    rd_q_ff;
   logic          rd_zero_ff;
   logic [CW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          wr_en;

   logic          accept;
   logic          do_append;
   logic          trigger;
   logic          check_ok;
   logic [2:0]    chan;
   logic          slot_free;
   logic [11:0]   raw;

   sfcd_parser u_parser (
      .mode    (mode_ff),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .result  (parse)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (seq_ff == sfcd_pkg::SEQ_ACCEPT);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign do_append = accept && !parse.clear && parse.append &&
                      (count_ff < CW'(sfcd_pkg::LINE_BYTES));
   assign wr_en     = do_append && (count_ff < CW'(sfcd_pkg::PACKET_BYTES));
   assign check_ok  = (acc_ff == parse.data) && (type_ff == cfg_ff.frame_type);

   assign rd_addr = CW'(1) + CW'({pair_ff, 1'b0}) + CW'(pair_ff) + CW'(step_ff);
   assign rd_data = rd_zero_ff ? 8'h00 : rd_q_ff;
   assign chan    = {pair_ff, half_ff};
   assign raw     = sfcd_pkg::chan_raw(half_ff, b0_ff, b1_ff, b2_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[AW-1:0]] <= parse.data;
      end
      rd_q_ff    <= store_mem[rd_addr[AW-1:0]];
      rd_zero_ff <= (rd_addr >= CW'(sfcd_pkg::PACKET_BYTES));
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            sfcd_pkg::CSR_DELIMITER:  cfg_in.delimiter  = csr_data;
            sfcd_pkg::CSR_ESCAPE:     cfg_in.escape     = csr_data;
            sfcd_pkg::CSR_MASK:       cfg_in.mask       = csr_data;
            sfcd_pkg::CSR_FRAME_TYPE: cfg_in.frame_type = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      acc_in   = acc_ff;
      type_in  = type_ff;
      if (accept && parse.clear) begin
         count_in = '0;
      end else if (do_append) begin
         count_in = count_ff + CW'(1);
         if (count_ff == '0) begin
            acc_in  = parse.data;
            type_in = parse.data;
         end else if (count_ff < CW'(sfcd_pkg::PACKET_BYTES - 1)) begin
            acc_in = acc_ff ^ parse.data;
         end
      end
      trigger = accept && (count_in == CW'(sfcd_pkg::PACKET_BYTES)) &&
                (count_ff != CW'(sfcd_pkg::PACKET_BYTES));
      mode_in = mode_ff;
      if (accept) begin
         mode_in = trigger ? sfcd_pkg::MODE_IDLE : parse.next_mode;
      end
   end

   always_comb begin
      seq_in       = seq_ff;
      pair_in      = pair_ff;
      half_in      = half_ff;
      step_in      = step_ff;
      b0_in        = b0_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      case (seq_ff)
         sfcd_pkg::SEQ_ACCEPT: begin
            if (trigger && check_ok) begin
               seq_in  = sfcd_pkg::SEQ_LOAD;
               pair_in = '0;
               half_in = 1'b0;
               step_in = '0;
            end
         end
         sfcd_pkg::SEQ_LOAD: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd1:    b0_in = rd_data;
               2'd2:    b1_in = rd_data;
               2'd3: begin
                  b2_in  = rd_data;
                  seq_in = sfcd_pkg::SEQ_EMIT;
               end
               default: b0_in = b0_ff;
            endcase
         end
         sfcd_pkg::SEQ_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = chan;
               rsp_value_in = {1'b0, raw} - sfcd_pkg::CHANNEL_OFFSET;
               rsp_last_in  = (chan == 3'(sfcd_pkg::CHAN_COUNT - 1));
               if (chan == 3'(sfcd_pkg::CHAN_COUNT - 1)) begin
                  seq_in = sfcd_pkg::SEQ_ACCEPT;
               end else if (half_ff) begin
                  seq_in  = sfcd_pkg::SEQ_LOAD;
                  pair_in = pair_ff + 2'd1;
                  half_in = 1'b0;
                  step_in = '0;
               end else begin
                  half_in = 1'b1;
               end
            end
         end
         default: seq_in = sfcd_pkg::SEQ_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{delimiter:  sfcd_pkg::RST_DELIMITER,
                           escape:     sfcd_pkg::RST_ESCAPE,
                           mask:       sfcd_pkg::RST_MASK,
                           frame_type: sfcd_pkg::RST_FRAME_TYPE};
         mode_ff      <= sfcd_pkg::MODE_IDLE;
         seq_ff       <= sfcd_pkg::SEQ_ACCEPT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         mode_ff      <= mode_in;
         seq_ff       <= seq_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      type_ff      <= type_in;
      pair_ff      <= pair_in;
      half_ff      <= half_in;
      step_ff      <= step_in;
      b0_ff        <= b0_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sfcd_checker.sv =====
// Port-level checker for the stuffed frame channel decoder and its bind statement.
// Depends on sfcd_pkg and stuffed_frame_channel_decoder_core.
`default_nettype none

module sfcd_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [15:0]                 rsp_tdata,
   input wire logic                        rsp_tlast
);

   // A result that is held back keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // While a frame is still being emitted, no new byte is taken.
   a_no_req_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("byte accepted during channel output");

   // The last result of a frame carries the highest channel index.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[2:0] == 3'(sfcd_pkg::CHAN_COUNT - 1))
      else $error("last channel has wrong index");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind stuffed_frame_channel_decoder_core sfcd_checker u_sfcd_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for stuffed_frame_channel_decoder_core.
// It drives stuffed byte streams, predicts the decoded channels and checks each result item.
// It depends on sfcd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int STALL_LIMIT    = 3000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int HOLDOFF_CYCLES = 400;

   typedef struct packed {
      logic [2:0]  index;
      logic [12:0] value;
      logic        last;
   } channel_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_TYPE,
      FRAME_CUT
   } frame_kind_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = 8'h00;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [15:0]                rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [sfcd_pkg::CSR_W-1:0] csr_index = sfcd_pkg::CSR_DELIMITER;
   logic [7:0]                 csr_data = 8'h00;

   logic [7:0]  wire_bytes[$];
   logic [7:0]  burst[$];
   channel_type pending_channels[$];

   sfcd_pkg::cfg_type  rx_cfg = {sfcd_pkg::RST_DELIMITER, sfcd_pkg::RST_ESCAPE,
                                 sfcd_pkg::RST_MASK, sfcd_pkg::RST_FRAME_TYPE};
   sfcd_pkg::mode_type rx_mode = sfcd_pkg::MODE_IDLE;
   logic [5:0]         rx_count = '0;
   logic [7:0]         rx_store[sfcd_pkg::PACKET_BYTES];

   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int holdoff_left = 0;
   bit holdoff_go = 1'b0;
   bit holdoff_used = 1'b0;
   int mismatch_count = 0;
   int idle_cycles = 0;

   stuffed_frame_channel_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic store_rx_byte(input logic [7:0] b);
      if (rx_count < sfcd_pkg::LINE_BYTES) begin
         if (rx_count < sfcd_pkg::PACKET_BYTES) begin
            rx_store[rx_count] = b;
         end
         rx_count = rx_count + 6'd1;
      end
   endtask

   function automatic logic [7:0] frame_byte(input int pos);
      return (pos < sfcd_pkg::PACKET_BYTES) ? rx_store[pos] : 8'h00;
   endfunction

   task automatic parse_rx_byte(input logic [7:0] b);
      logic [5:0]  prev_count;
      logic [7:0]  sum;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [11:0] raw;
      int          base;
      channel_type chan;
      prev_count = rx_count;
      case (rx_mode)
         sfcd_pkg::MODE_IDLE: begin
            if (b == rx_cfg.delimiter) begin
               rx_count = '0;
               rx_mode = sfcd_pkg::MODE_START;
            end else begin
               store_rx_byte(b);
            end
         end
         sfcd_pkg::MODE_START: begin
            if (b == rx_cfg.delimiter) begin
               rx_count = '0;
               rx_mode = sfcd_pkg::MODE_FRAME;
            end else begin
               store_rx_byte(b);
            end
         end
         sfcd_pkg::MODE_FRAME: begin
            if (b == rx_cfg.escape) begin
               rx_mode = sfcd_pkg::MODE_ESC;
            end else if (b == rx_cfg.delimiter) begin
               rx_count = '0;
            end else begin
               store_rx_byte(b);
            end
         end
         default: begin
            if (b == (rx_cfg.escape ^ rx_cfg.mask) || b == (rx_cfg.delimiter ^ rx_cfg.mask)) begin
               store_rx_byte(b ^ rx_cfg.mask);
               rx_mode = sfcd_pkg::MODE_FRAME;
            end else if (b == rx_cfg.delimiter) begin
               rx_count = '0;
               rx_mode = sfcd_pkg::MODE_FRAME;
            end else begin
               rx_mode = sfcd_pkg::MODE_START;
            end
         end
      endcase
      if (rx_count == sfcd_pkg::PACKET_BYTES && prev_count != sfcd_pkg::PACKET_BYTES) begin
         sum = 8'h00;
         for (int i = 0; i < sfcd_pkg::PACKET_BYTES - 1; i++) begin
            sum = sum ^ rx_store[i];
         end
         if (sum == rx_store[sfcd_pkg::PACKET_BYTES-1] &&
             rx_store[0] == rx_cfg.frame_type) begin
            for (int ch = 0; ch < sfcd_pkg::CHAN_COUNT; ch++) begin
               base = 1 + 3 * (ch / 2);
               b0 = frame_byte(base);
               b1 = frame_byte(base + 1);
               b2 = frame_byte(base + 2);
               if (ch % 2 == 0) begin
                  raw = 12'(b0) + (12'(b1 & 8'hf0) << 4);
               end else begin
                  raw = (12'(b1 & 8'h0f) << 4) + 12'(b2 >> 4) + (12'(b2 & 8'h0f) << 8);
               end
               chan.index = 3'(ch);
               chan.value = 13'(raw) - sfcd_pkg::CHANNEL_OFFSET;
               chan.last = (ch == sfcd_pkg::CHAN_COUNT - 1);
               pending_channels.push_back(chan);
            end
         end
         rx_mode = sfcd_pkg::MODE_IDLE;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (wire_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= wire_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      channel_type got;
      channel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[2:0];
            got.value = rsp_tdata[15:3];
            got.last = rsp_tlast;
            if (pending_channels.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("unexpected channel item: index %0d value %0d last %0b",
                           got.index, $signed(got.value), got.last);
               end
               mismatch_count++;
            end else begin
               want = pending_channels.pop_front();
               if (got != want) begin
                  if (mismatch_count < 10) begin
                     $display({"channel mismatch: expected index %0d value %0d last %0b,",
                               " got index %0d value %0d last %0b"},
                              want.index, $signed(want.value), want.last,
                              got.index, $signed(got.value), got.last);
                  end
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (holdoff_go && !holdoff_used) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_used <= 1'b1;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [sfcd_pkg::CSR_W-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         sfcd_pkg::CSR_DELIMITER:  rx_cfg.delimiter = value;
         sfcd_pkg::CSR_ESCAPE:     rx_cfg.escape = value;
         sfcd_pkg::CSR_MASK:       rx_cfg.mask = value;
         sfcd_pkg::CSR_FRAME_TYPE: rx_cfg.frame_type = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      while (wire_bytes.size() != 0 || req_tvalid || pending_channels.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic begin_phase(input sfcd_pkg::cfg_type c, input int send_pct,
                              input int recv_pct);
      drain();
      write_reg(sfcd_pkg::CSR_DELIMITER, c.delimiter);
      write_reg(sfcd_pkg::CSR_ESCAPE, c.escape);
      write_reg(sfcd_pkg::CSR_MASK, c.mask);
      write_reg(sfcd_pkg::CSR_FRAME_TYPE, c.frame_type);
      @(negedge clock);
      send_gap_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   function automatic sfcd_pkg::cfg_type random_config();
      sfcd_pkg::cfg_type c;
      c.delimiter = 8'($urandom);
      do c.escape = 8'($urandom); while (c.escape == c.delimiter);
      c.mask = 8'($urandom);
      c.frame_type = 8'($urandom);
      return c;
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      case ($urandom_range(9))
         0: b = rx_cfg.escape;
         1: b = rx_cfg.delimiter;
         2: b = rx_cfg.escape ^ rx_cfg.mask;
         3: b = rx_cfg.delimiter ^ rx_cfg.mask;
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   // The channel bytes cancel in pairs, so the checksum equals the type byte.
   task automatic queue_flat_frame(input logic [7:0] fill);
      wire_bytes.push_back(rx_cfg.frame_type);
      repeat (sfcd_pkg::PACKET_BYTES - 2) wire_bytes.push_back(fill);
      wire_bytes.push_back(rx_cfg.frame_type);
   endtask

   task automatic build_frame(input frame_kind_type kind);
      logic [7:0] body[sfcd_pkg::PACKET_BYTES];
      logic [7:0] sum;
      int         cut;
      sum = 8'h00;
      body[0] = rx_cfg.frame_type;
      if (kind == FRAME_BAD_TYPE) begin
         body[0] = body[0] ^ 8'($urandom_range(255, 1));
      end
      for (int i = 1; i < sfcd_pkg::PACKET_BYTES - 1; i++) begin
         body[i] = pick_byte();
      end
      for (int i = 0; i < sfcd_pkg::PACKET_BYTES - 1; i++) begin
         sum = sum ^ body[i];
      end
      if (kind == FRAME_BAD_SUM) begin
         sum = sum ^ 8'($urandom_range(255, 1));
      end
      body[sfcd_pkg::PACKET_BYTES-1] = sum;
      burst.push_back(rx_cfg.delimiter);
      burst.push_back(rx_cfg.delimiter);
      for (int i = 0; i < sfcd_pkg::PACKET_BYTES; i++) begin
         if (body[i] == rx_cfg.escape || body[i] == rx_cfg.delimiter) begin
            burst.push_back(rx_cfg.escape);
            burst.push_back(body[i] ^ rx_cfg.mask);
         end else begin
            burst.push_back(body[i]);
         end
      end
      if (kind == FRAME_CUT) begin
         cut = $urandom_range(burst.size() - 1, 3);
         while (burst.size() > cut) void'(burst.pop_back());
      end
   endtask

   task automatic build_noise();
      int         len;
      bit         plain;
      logic [7:0] b;
      len = $urandom_range(40, 1);
      plain = 1'($urandom_range(1));
      repeat (len) begin
         b = pick_byte();
         if (plain && b == rx_cfg.delimiter) begin
            b = ~b;
         end
         burst.push_back(b);
      end
   endtask

   task automatic push_traffic(input int n_items);
      int pushed;
      int pick;
      pushed = 0;
      while (pushed < n_items) begin
         burst.delete();
         pick = $urandom_range(9);
         if (pick < 6) begin
            build_frame(FRAME_GOOD);
         end else if (pick == 6) begin
            build_frame(FRAME_BAD_SUM);
         end else if (pick == 7) begin
            build_frame(FRAME_BAD_TYPE);
         end else if (pick == 8) begin
            build_frame(FRAME_CUT);
         end else begin
            build_noise();
         end
         pushed += burst.size();
         foreach (burst[i]) wire_bytes.push_back(burst[i]);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      begin_phase({sfcd_pkg::RST_DELIMITER, sfcd_pkg::RST_ESCAPE,
                   sfcd_pkg::RST_MASK, sfcd_pkg::RST_FRAME_TYPE}, 0, 0);
      // A frame taken straight from reset in idle mode, then one taken in start mode.
      queue_flat_frame(8'h00);
      wire_bytes.push_back(rx_cfg.delimiter);
      queue_flat_frame(8'hff);
      push_traffic(30);

      begin_phase({8'h00, 8'hff, 8'hff, 8'h00}, 81, 0);
      push_traffic(30);

      begin_phase({8'hff, 8'h00, 8'h00, 8'hff}, 0, 81);
      holdoff_go = 1'b1;
      push_traffic(30);

      begin_phase(random_config(), 24, 24);
      push_traffic(30);

      begin_phase(random_config(), 0, 0);
      push_traffic(30);

      drain();
      if (mismatch_count == 0 && pending_channels.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/sfcd_pkg.sv
hw/rtl/sfcd_parser.sv
hw/rtl/stuffed_frame_channel_decoder_core.sv
hw/rtl/sfcd_checker.sv
test/testbench.sv
